FILE: rtl/pcwrl_pkg.sv
// Shared types and constants for the per-client window rate limiter.
package pcwrl_pkg;

  localparam int SLOTS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_FORGET = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_MAX    = 2'd1;
  localparam logic [1:0] CFG_ACTIVE = 2'd2;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic start;       // latch request, reset scan
    logic scan;        // process the slot under the read pointer
    logic finish;      // write back and produce the result
    logic mod_step;    // one step of lfsr mod n
  } pcwrl_cmd_t;

  typedef struct packed {
    logic scan_done;   // last slot processed or match found
    logic need_mod;    // check without match and without candidate
    logic mod_done;
  } pcwrl_status_t;

endpackage

FILE: rtl/pcwrl_datapath.sv
// Slot table, scan registers, LFSR and remainder unit.
module pcwrl_datapath import pcwrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  pcwrl_cmd_t          cmd,
  output pcwrl_status_t       status,
  input  logic [1:0]          req_type,
  input  logic [63:0]         client_key,
  input  logic [31:0]         now_time,
  input  logic [16:0]         window_length,
  input  logic [15:0]         max_requests,
  input  logic [6:0]          active_slots,
  output logic                limited,
  output logic [5:0]          slot_used
);

  logic [SLOTS-1:0] valid;
  logic [63:0] key_mem [SLOTS];
  logic [15:0] cnt_mem [SLOTS];
  logic [31:0] ws_mem [SLOTS];
  logic [31:0] la_mem [SLOTS];

  logic [63:0] rd_key;
  logic [15:0] rd_cnt;
  logic [31:0] rd_ws;
  logic [31:0] rd_la;

  logic [1:0]  rtype;
  logic [63:0] rkey;
  logic [31:0] rnow;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] idx;
  logic        found;
  logic [SLOT_W-1:0] hit;
  logic        have_cand;
  logic [SLOT_W-1:0] cand;
  logic [32:0] oldest;
  logic [15:0] lfsr;
  logic [16:0] rem;
  logic [4:0]  mod_bit;
  logic        modding;

  logic [SLOT_W-1:0] sidx;
  logic [SLOT_W-1:0] raddr;
  logic [CNT_W-1:0]  n_calc;
  logic        expired, match, older;
  logic        hold_idx, advance;
  logic [15:0] lfsr_step;
  logic [16:0] rem_sh;

  assign sidx = idx[SLOT_W-1:0];

  always_comb begin
    if (active_slots == 7'd0) n_calc = CNT_W'(1);
    else if (32'(active_slots) > 32'(SLOTS)) n_calc = CNT_W'(SLOTS);
    else n_calc = CNT_W'(active_slots);
  end

  assign expired = (rnow - rd_ws) >= 32'(window_length);
  assign match = rd_key == rkey;
  assign older = {1'b0, rd_la} < oldest;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  // a live match stops the scan on the current slot
  assign hold_idx = ((rtype == REQ_FORGET) || (rtype == REQ_CHECK)) && valid[sidx] && match &&
                    (rtype == REQ_FORGET || !expired);
  assign advance = cmd.scan && !hold_idx;

  // prefetch the slot that the next cycle works on
  assign raddr = cmd.start ? '0 : (advance ? sidx + SLOT_W'(1) : sidx);

  always_ff @(posedge clk) begin
    rd_key <= key_mem[raddr];
    rd_cnt <= cnt_mem[raddr];
    rd_ws <= ws_mem[raddr];
    rd_la <= la_mem[raddr];
  end

  always_comb begin
    rem_sh = {rem[15:0], lfsr[mod_bit[3:0]]};
    if (rem_sh >= 17'(n)) rem_sh = rem_sh - 17'(n);
  end

  assign status.scan_done = found || (idx >= n);
  assign status.need_mod = (rtype == REQ_CHECK) && !found && !have_cand;
  assign status.mod_done = modding && (mod_bit == 5'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      lfsr <= LFSR_SEED;
      modding <= 1'b0;
    end else if (cmd.start) begin
      rtype <= req_type;
      rkey <= client_key;
      rnow <= now_time;
      n <= n_calc;
      idx <= '0;
      found <= 1'b0;
      have_cand <= 1'b0;
      cand <= '0;
      oldest <= {1'b0, now_time} + 33'd1;
      modding <= 1'b0;
      if (req_type == REQ_CLEAR) valid <= '0;
    end else if (cmd.scan) begin
      if ((rtype == REQ_FORGET) || (rtype == REQ_CHECK)) begin
        if (!valid[sidx]) begin
          if (rtype == REQ_CHECK && !have_cand) begin
            have_cand <= 1'b1;
            cand <= sidx;
          end
        end else if (rtype == REQ_FORGET) begin
          if (match) begin
            valid[sidx] <= 1'b0;
            found <= 1'b1;
          end
        end else if (expired) begin
          valid[sidx] <= 1'b0;
          if (!have_cand || older) begin
            have_cand <= 1'b1;
            cand <= sidx;
            oldest <= {1'b0, rd_la};
          end
        end else if (match) begin
          found <= 1'b1;
          hit <= sidx;
        end else if (older) begin
          have_cand <= 1'b1;
          cand <= sidx;
          oldest <= {1'b0, rd_la};
        end
      end else begin
        found <= 1'b1;
      end
      if (advance) idx <= idx + CNT_W'(1);
    end else if (cmd.mod_step) begin
      // advance LFSR once, then reduce it mod n bit by bit
      if (!modding) begin
        lfsr <= lfsr_step;
        modding <= 1'b1;
        mod_bit <= 5'd15;
        rem <= '0;
      end else if (mod_bit != 5'd31) begin
        rem <= rem_sh;
        mod_bit <= (mod_bit == 5'd0) ? 5'd31 : mod_bit - 5'd1;
      end
    end else if (cmd.finish) begin
      limited <= 1'b0;
      slot_used <= '0;
      if (rtype == REQ_CHECK) begin
        if (found) begin
          la_mem[hit] <= rnow;
          slot_used <= 6'(hit);
          if (rd_cnt >= max_requests) limited <= 1'b1;
          else cnt_mem[hit] <= rd_cnt + 16'd1;
        end else begin
          valid[have_cand ? cand : SLOT_W'(rem)] <= 1'b1;
          key_mem[have_cand ? cand : SLOT_W'(rem)] <= rkey;
          cnt_mem[have_cand ? cand : SLOT_W'(rem)] <= 16'd1;
          ws_mem[have_cand ? cand : SLOT_W'(rem)] <= rnow;
          la_mem[have_cand ? cand : SLOT_W'(rem)] <= rnow;
          slot_used <= 6'(have_cand ? cand : SLOT_W'(rem));
        end
      end
    end
  end

endmodule

FILE: rtl/pcwrl_ctrl.sv
// Sequencer for scan, remainder and write-back phases.
module pcwrl_ctrl import pcwrl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output pcwrl_cmd_t    cmd,
  input  pcwrl_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MOD  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          if (status.need_mod) state_next = S_MOD;
          else state_next = S_FIN;
        end else cmd.scan = 1'b1;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

FILE: rtl/per_client_window_rate_limiter.sv
// Top level of the per-client window rate limiter.
//  channel  signals                                    direction
//  in       in_valid/in_stall, req_type,key,now_time   into block
//  out      out_valid/out_stall, limited, slot_used     out of block
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data    into block
// A check or forget passes through an accept state, a scan over the slots, a scan-end,
// a write-back and a result state; the scan stops early on a match.
// A claim with no free candidate also runs the LFSR remainder before the write-back.
// Clear and unknown requests end the scan after the first slot. One word is in flight at a time.
// Reset empties the table at once. The result holds in place while out_stall is high.
module per_client_window_rate_limiter import pcwrl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] client_key,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        limited,
  output logic [5:0]  slot_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pcwrl_cmd_t    cmd;
  pcwrl_status_t status;
  logic [16:0] window_length;
  logic [15:0] max_requests;
  logic [6:0]  active_slots;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 17'd60;
      max_requests <= 16'd10;
      active_slots <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW: window_length <= cfg_data[16:0];
        CFG_MAX:    max_requests <= cfg_data[15:0];
        CFG_ACTIVE: active_slots <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  pcwrl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .status
  );

  pcwrl_datapath u_dp (
    .clk, .rst, .cmd, .status, .req_type, .client_key, .now_time,
    .window_length, .max_requests, .active_slots, .limited, .slot_used
  );

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot_used) && $stable(limited))
    else $error("result changed while stalled");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.scan, cmd.finish, cmd.mod_step}))
    else $error("conflicting commands");

endmodule
